### rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash engine: initial vector, round
// constants, sequencer states and the message-schedule control bundle.
// ----------------------------------------------------------------------------
package sha1_pkg;

    // Initial chaining value
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K1 = 32'h5A827999;
    localparam logic [31:0] K2 = 32'h6ED9EBA1;
    localparam logic [31:0] K3 = 32'h8F1BBCDC;
    localparam logic [31:0] K4 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] LEN_POS     = 7'd56;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [6:0] PHASE2      = 7'd20;
    localparam logic [6:0] PHASE3      = 7'd40;
    localparam logic [6:0] PHASE4      = 7'd60;
    localparam logic [2:0] WORD_BYTES  = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PAD,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_RUN,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Control of the message schedule shift line
    typedef struct packed {
        logic        push;     // shift in nbytes leading bytes of src
        logic [2:0]  nbytes;   // 0..4
        logic [31:0] src;
        logic        expand;   // one schedule step of a round
    } t_sched_ctrl;

endpackage

### rtl/sha1_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_round
// Round function of the compression: selects f and K by round index and
// forms the new working value a.
// ----------------------------------------------------------------------------
module sha1_round (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_e,
    input  logic [31:0] i_w,
    input  logic [6:0]  i_round,
    output logic [31:0] o_t
);

    logic [31:0] f;
    logic [31:0] k;

    // Boolean function and constant per phase
    always_comb begin
        if (i_round < sha1_pkg::PHASE2) begin
            f = i_d ^ (i_b & (i_c ^ i_d));
            k = sha1_pkg::K1;
        end else if (i_round < sha1_pkg::PHASE3) begin
            f = i_b ^ i_c ^ i_d;
            k = sha1_pkg::K2;
        end else if (i_round < sha1_pkg::PHASE4) begin
            f = (i_b & i_c) | (i_d & (i_b | i_c));
            k = sha1_pkg::K3;
        end else begin
            f = i_b ^ i_c ^ i_d;
            k = sha1_pkg::K4;
        end
    end

    // rotl(a,5) + f + e + K + W
    assign o_t = {i_a[26:0], i_a[31:27]} + f + i_e + k + i_w;

endmodule

### rtl/sha1_msg_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_msg_sched
// 512-bit block buffer and message schedule in one shift line. Bytes shift in
// at the low end; during the rounds whole words shift out at the high end
// while the expanded word enters at the low end.
// ----------------------------------------------------------------------------
module sha1_msg_sched (
    input  logic                  i_clk,
    input  sha1_pkg::t_sched_ctrl i_ctrl,
    output logic [31:0]           o_w
);

    logic [511:0] r_msg;
    logic [511:0] n_msg;
    logic [31:0]  x;

    // Word k of the line sits at bits 511-32k downward; word 0 is W[i]
    assign o_w = r_msg[511:480];
    assign x   = r_msg[95:64] ^ r_msg[255:224] ^ r_msg[447:416] ^ r_msg[511:480];

    // Byte insertion or schedule step
    always_comb begin
        n_msg = r_msg;
        if (i_ctrl.expand) begin
            n_msg = {r_msg[479:0], x[30:0], x[31]};
        end else if (i_ctrl.push) begin
            case (i_ctrl.nbytes)
                3'd1:    n_msg = {r_msg[503:0], i_ctrl.src[31:24]};
                3'd2:    n_msg = {r_msg[495:0], i_ctrl.src[31:16]};
                3'd3:    n_msg = {r_msg[487:0], i_ctrl.src[31:8]};
                3'd4:    n_msg = {r_msg[479:0], i_ctrl.src};
                default: n_msg = r_msg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
    end

endmodule

### rtl/sha1_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine
// Streaming SHA-1 over a byte message with padding, length trailer and
// digest output.
// ----------------------------------------------------------------------------
// A beat carries one big-endian word with 0..4 leading valid bytes (counts
// above four act as four) and a last flag. A beat whose bytes fit in the
// current 64-byte block goes into it whole. Each filled block runs through
// the single round unit, one round per cycle, then folds into the chaining
// value, during which no beat is taken; a beat straddling a block boundary
// is held and pushes its remaining bytes after the fold. On the last beat
// the sequencer appends 0x80, zero fill at up to four bytes a cycle (paused
// while a block is compressed, and running into an extra block when the pad
// needs one), the 64-bit length, runs the final block(s), and loads the
// digest into the output register. The digest waits there for its beat to
// be taken while the next message is already streaming in; the engine then
// restarts from the initial vector. No clearing pass is needed at reset.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3,
    output logic [31:0] o_digest_word4
);

    sha1_pkg::t_state r_state, n_state;
    sha1_pkg::t_state r_ret, n_ret;

    logic [6:0]  r_fill;
    logic [31:0] r_word;
    logic [2:0]  r_left;
    logic        r_last;
    logic [63:0] r_bits;
    logic [31:0] r_chain [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic        r_out_valid;
    logic [31:0] r_dig [5];

    logic        accept;
    logic [2:0]  cnt_sat;
    logic        push_en;
    logic [31:0] src;
    logic [2:0]  want;
    logic [6:0]  room;
    logic [6:0]  gap;
    logic [2:0]  n;
    logic [6:0]  fill_next;
    logic        full;
    logic [2:0]  left_after;
    logic [31:0] word_after;
    sha1_pkg::t_state follow;
    logic        out_load;
    logic [31:0] w_cur;
    logic [31:0] t_new;
    sha1_pkg::t_sched_ctrl sched_ctrl;

    assign o_in_ready = (r_state == sha1_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_sat    = (i_byte_count > sha1_pkg::WORD_BYTES) ? sha1_pkg::WORD_BYTES
                                                              : i_byte_count;
    assign out_load   = (r_state == sha1_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    // Byte source for the push path, per state
    always_comb begin
        push_en = 1'b0;
        src     = 32'd0;
        want    = 3'd0;
        gap     = (r_fill > sha1_pkg::LEN_POS) ? (sha1_pkg::BLOCK_BYTES - r_fill)
                                               : (sha1_pkg::LEN_POS - r_fill);
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                push_en = accept;
                src     = i_data_word;
                want    = cnt_sat;
            end
            sha1_pkg::ST_PUSH: begin
                push_en = 1'b1;
                src     = r_word;
                want    = r_left;
            end
            sha1_pkg::ST_PAD: begin
                push_en = 1'b1;
                src     = {sha1_pkg::PAD_BYTE, 24'd0};
                want    = 3'd1;
            end
            sha1_pkg::ST_ZERO: begin
                push_en = 1'b1;
                want    = (gap > 7'd4) ? sha1_pkg::WORD_BYTES : gap[2:0];
            end
            sha1_pkg::ST_LEN_HI: begin
                push_en = 1'b1;
                src     = r_bits[63:32];
                want    = sha1_pkg::WORD_BYTES;
            end
            sha1_pkg::ST_LEN_LO: begin
                push_en = 1'b1;
                src     = r_bits[31:0];
                want    = sha1_pkg::WORD_BYTES;
            end
            default: begin
                push_en = 1'b0;
            end
        endcase
    end

    // Bytes that fit in the current block
    assign room       = sha1_pkg::BLOCK_BYTES - r_fill;
    assign n          = ({4'd0, want} < room) ? want : room[2:0];
    assign fill_next  = r_fill + {4'd0, n};
    assign full       = (fill_next == sha1_pkg::BLOCK_BYTES);
    assign left_after = want - n;
    assign word_after = src << {n, 3'b000};

    // State that follows a push once any compression is done
    always_comb begin
        case (r_state)
            sha1_pkg::ST_IDLE: begin
                follow = (left_after != 3'd0) ? sha1_pkg::ST_PUSH
                       : (i_last_word ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE);
            end
            sha1_pkg::ST_PUSH: begin
                follow = (left_after != 3'd0) ? sha1_pkg::ST_PUSH
                       : (r_last ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE);
            end
            sha1_pkg::ST_PAD:    follow = sha1_pkg::ST_ZERO;
            sha1_pkg::ST_ZERO: begin
                follow = (fill_next == sha1_pkg::LEN_POS) ? sha1_pkg::ST_LEN_HI
                                                          : sha1_pkg::ST_ZERO;
            end
            sha1_pkg::ST_LEN_HI: follow = sha1_pkg::ST_LEN_LO;
            sha1_pkg::ST_LEN_LO: follow = sha1_pkg::ST_OUT;
            default:             follow = sha1_pkg::ST_IDLE;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            sha1_pkg::ST_IDLE, sha1_pkg::ST_PUSH, sha1_pkg::ST_PAD, sha1_pkg::ST_ZERO,
            sha1_pkg::ST_LEN_HI, sha1_pkg::ST_LEN_LO: begin
                if (push_en) begin
                    n_state = full ? sha1_pkg::ST_RUN : follow;
                    n_ret   = follow;
                end
            end
            sha1_pkg::ST_RUN: begin
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_state = sha1_pkg::ST_FOLD;
                end
            end
            sha1_pkg::ST_FOLD: n_state = r_ret;
            sha1_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = sha1_pkg::ST_IDLE;
                end
            end
            default: n_state = sha1_pkg::ST_IDLE;
        endcase
    end

    // Schedule control
    always_comb begin
        sched_ctrl.push   = push_en;
        sched_ctrl.nbytes = n;
        sched_ctrl.src    = src;
        sched_ctrl.expand = (r_state == sha1_pkg::ST_RUN);
    end

    sha1_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w    (w_cur)
    );

    sha1_round u_round (
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_e     (r_e),
        .i_w     (w_cur),
        .i_round (r_round),
        .o_t     (t_new)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1_pkg::ST_IDLE;
            r_ret       <= sha1_pkg::ST_IDLE;
            r_fill      <= 7'd0;
            r_left      <= 3'd0;
            r_last      <= 1'b0;
            r_bits      <= 64'd0;
            r_round     <= 7'd0;
            r_out_valid <= 1'b0;
            r_chain[0]  <= sha1_pkg::IV0;
            r_chain[1]  <= sha1_pkg::IV1;
            r_chain[2]  <= sha1_pkg::IV2;
            r_chain[3]  <= sha1_pkg::IV3;
            r_chain[4]  <= sha1_pkg::IV4;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;

            if (push_en) begin
                r_fill <= full ? 7'd0 : fill_next;
            end

            if (accept) begin
                r_left <= left_after;
                r_last <= i_last_word;
                r_bits <= r_bits + {58'd0, cnt_sat, 3'b000};
            end else if (r_state == sha1_pkg::ST_PUSH) begin
                r_left <= left_after;
            end

            r_round <= (r_state == sha1_pkg::ST_RUN) ? r_round + 7'd1 : 7'd0;

            // Fold the working values, or restart the chain after output
            if (r_state == sha1_pkg::ST_FOLD) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end else if (out_load) begin
                r_chain[0] <= sha1_pkg::IV0;
                r_chain[1] <= sha1_pkg::IV1;
                r_chain[2] <= sha1_pkg::IV2;
                r_chain[3] <= sha1_pkg::IV3;
                r_chain[4] <= sha1_pkg::IV4;
                r_bits     <= 64'd0;
            end

            // Output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: held word, working values, digest
    always_ff @(posedge i_clk) begin
        if (accept || (r_state == sha1_pkg::ST_PUSH)) begin
            r_word <= word_after;
        end

        if (r_state == sha1_pkg::ST_RUN) begin
            r_a <= t_new;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end

        if (out_load) begin
            r_dig[0] <= r_chain[0];
            r_dig[1] <= r_chain[1];
            r_dig[2] <= r_chain[2];
            r_dig[3] <= r_chain[3];
            r_dig[4] <= r_chain[4];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_dig[0];
    assign o_digest_word1 = r_dig[1];
    assign o_digest_word2 = r_dig[2];
    assign o_digest_word3 = r_dig[3];
    assign o_digest_word4 = r_dig[4];

endmodule
